@@ hdl/sbba_pkg.sv @@
// sbba_pkg: shared constants, config register indexes, reciprocal table and
// sequencer state type for the separable box blur unit. No dependencies.
`timescale 1ns / 1ps

package sbba_pkg;

    // default sizes of the storage
    localparam int MAX_RADIUS_DEF = 10;
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    // config port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_ADDR_W-1:0] CFG_BLUR_RADIUS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int RADIUS_FIELD_W = 4;
    localparam int WIDTH_FIELD_W  = 12;
    localparam int HEIGHT_FIELD_W = 13;

    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // pixel layout
    localparam int CHAN_W  = 8;
    localparam int N_CHAN  = 4;
    localparam int PIXEL_W = 32;

    // floor(sum / (2r+1)) as (sum * recip(r)) >> RECIP_SHIFT, exact for r <= 16
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;

    function automatic logic [RECIP_W-1:0] recip_mult(input logic [4:0] r);
        logic [RECIP_W-1:0] m;
        case (r)
            5'd0:    m = 21'd1048576;
            5'd1:    m = 21'd349526;
            5'd2:    m = 21'd209716;
            5'd3:    m = 21'd149797;
            5'd4:    m = 21'd116509;
            5'd5:    m = 21'd95326;
            5'd6:    m = 21'd80660;
            5'd7:    m = 21'd69906;
            5'd8:    m = 21'd61681;
            5'd9:    m = 21'd55189;
            5'd10:   m = 21'd49933;
            5'd11:   m = 21'd45591;
            5'd12:   m = 21'd41944;
            5'd13:   m = 21'd38837;
            5'd14:   m = 21'd36158;
            5'd15:   m = 21'd33826;
            5'd16:   m = 21'd31776;
            default: m = 21'd31776;
        endcase
        return m;
    endfunction

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROC,
        ST_SETUP,
        ST_RD,
        ST_ACC,
        ST_HDONE,
        ST_HADD,
        ST_VDONE,
        ST_EMIT
    } seq_state_t;

endpackage

@@ hdl/sbba_line_store.sv @@
// sbba_line_store: ring of recent raw pixels, one write and one registered
// read port. Depends on nothing.
`timescale 1ns / 1ps

module sbba_line_store #(
    parameter int DEPTH  = 43029,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/sbba_recip_div.sv @@
// sbba_recip_div: per channel floor(sum / (2r+1)) by reciprocal multiply,
// result registered on enable. Depends on sbba_pkg.
`timescale 1ns / 1ps

module sbba_recip_div #(
    parameter int SUM_W = 14,
    parameter int R_W   = 4
) (
    input  logic                                        aclk,
    input  logic                                        en,
    input  logic [R_W-1:0]                              radius,
    input  logic [sbba_pkg::N_CHAN-1:0][SUM_W-1:0]      sum,
    output logic [sbba_pkg::N_CHAN-1:0][sbba_pkg::CHAN_W-1:0] quot
);

    localparam int PROD_W = SUM_W + sbba_pkg::RECIP_W;

    logic [sbba_pkg::RECIP_W-1:0]                 mult;
    logic [sbba_pkg::N_CHAN-1:0][PROD_W-1:0]      prod;
    logic [sbba_pkg::N_CHAN-1:0][sbba_pkg::CHAN_W-1:0] quot_reg;

    // reciprocal of the window length
    assign mult = sbba_pkg::recip_mult(5'(radius));

    // one multiply per channel
    always_comb begin
        for (int i = 0; i < sbba_pkg::N_CHAN; i++) begin
            prod[i] = PROD_W'(sum[i]) * PROD_W'(mult);
        end
    end

    // quotient register
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < sbba_pkg::N_CHAN; i++) begin
                quot_reg[i] <= prod[i][sbba_pkg::RECIP_SHIFT +: sbba_pkg::CHAN_W];
            end
        end
    end

    assign quot = quot_reg;

endmodule

@@ hdl/separable_box_blur_argb_unit.sv @@
// separable_box_blur_argb_unit: top level, sequencer around the line store
// and the reciprocal divider. Depends on sbba_pkg, sbba_line_store, sbba_recip_div.
`timescale 1ns / 1ps
//
// Usage
//   s_ channel: one request per pixel. s_tuser is the command (0 = pixel,
//   1 = drain one pending output after the frame's last pixel), s_tdata the
//   ARGB pixel. m_ channel: blurred ARGB pixel in m_tdata, m_tlast set on
//   the last pixel of the frame. Output p appears with input p + r*W + r;
//   drain requests flush the last r*W + r outputs.
//   cfg_we/cfg_addr/cfg_wdata write radius, width and height; a write to
//   any of the three restarts the frame.
// Sequencing
//   A request is taken only in the idle state, so one is handled at a time.
//   An output walks a window of 2v+1 rows of 2h+1 taps, where h and v are r or 0
//   for border columns and rows; every tap is a line store read, so the read
//   port sets the rate.
// Reset and stall
//   Synchronous active low reset clears counters and the output valid flag;
//   radius 0, 640 x 480. The line store needs no clearing.
//   A result waits in the output register while m_tready is low; the next
//   request is still taken, and its result waits until the register frees.
//
module separable_box_blur_argb_unit #(
    parameter int MAX_RADIUS = sbba_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = sbba_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbba_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config write port
    input  logic                            cfg_we,
    input  logic [sbba_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [sbba_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] pixel
    input  logic [0:0]                      s_tuser,   // [0] cmd
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // [31:0] out_pixel
    output logic                            m_tlast    // frame_end
);

    localparam int R_W      = $clog2(MAX_RADIUS + 1);
    localparam int W_W      = $clog2(MAX_WIDTH + 1);
    localparam int H_W      = $clog2(MAX_HEIGHT + 1);
    localparam int CNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DLY_W    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);
    localparam int LS_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int ADDR_W   = $clog2(LS_DEPTH);
    localparam int SUM_W    = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
    localparam int IDX_W    = R_W + 1;
    localparam int NCH      = sbba_pkg::N_CHAN;
    localparam int CW       = sbba_pkg::CHAN_W;
    localparam int W_RST    = (sbba_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                 : sbba_pkg::WIDTH_RST;
    localparam int H_RST    = (sbba_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                                   : sbba_pkg::HEIGHT_RST;

    sbba_pkg::seq_state_t state_reg, state_next;

    // settled configuration and derived sizes
    logic [R_W-1:0]   r_reg, r_next;
    logic [W_W-1:0]   w_reg, w_next;
    logic [H_W-1:0]   h_reg, h_next;
    logic [CNT_W-1:0] total_reg;
    logic [DLY_W-1:0] delay_reg;

    // frame counters
    logic [CNT_W-1:0]  in_count_reg, in_count_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [CNT_W-1:0]  out_index_reg, out_index_next;
    logic [W_W-1:0]    ox_reg, ox_next;
    logic [H_W-1:0]    oy_reg, oy_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    // window walk
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [IDX_W-1:0]  hidx_reg, hidx_next;
    logic [IDX_W-1:0]  vidx_reg, vidx_next;
    logic [IDX_W-1:0]  hlast_reg, hlast_next;
    logic [IDX_W-1:0]  vlast_reg, vlast_next;
    logic [W_W-1:0]    hstep_reg, hstep_next;
    logic              hnb_reg, hnb_next;
    logic              vnb_reg, vnb_next;
    logic [NCH-1:0][SUM_W-1:0] hsum_reg, hsum_next;
    logic [NCH-1:0][SUM_W-1:0] vsum_reg, vsum_next;

    // request and result registers
    logic        cmd_reg, cmd_next;
    logic [31:0] pix_reg, pix_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic        m_tlast_reg, m_tlast_next;

    // memory and divider hookup
    logic                  ls_we;
    logic [31:0]           ls_rd_data;
    logic                  div_en;
    logic [NCH-1:0][SUM_W-1:0] div_sum;
    logic [NCH-1:0][CW-1:0]    div_q;

    // combinational helpers
    logic [W_W+H_W-1:0]  total_full;
    logic [R_W+W_W-1:0]  delay_full;
    logic [ADDR_W-1:0]   step;
    logic [ADDR_W:0]     cur_sum, wr_sum, oa_sum, start_sum;
    logic [ADDR_W-1:0]   cur_adv, wr_adv, oa_adv, start_addr, offset;
    logic                set_hnb, set_vnb;
    logic [R_W-1:0]      hr, vr;
    logic                slot_free;
    logic                cfg_hit;
    logic [sbba_pkg::RADIUS_FIELD_W-1:0] cfg_r;
    logic [sbba_pkg::WIDTH_FIELD_W-1:0]  cfg_w;
    logic [sbba_pkg::HEIGHT_FIELD_W-1:0] cfg_h;

    sbba_line_store #(
        .DEPTH  (LS_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (sbba_pkg::PIXEL_W)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ls_we),
        .wr_addr (wr_addr_reg),
        .wr_data (pix_reg),
        .rd_addr (cursor_reg),
        .rd_data (ls_rd_data)
    );

    sbba_recip_div #(
        .SUM_W (SUM_W),
        .R_W   (R_W)
    ) u_div (
        .aclk   (aclk),
        .en     (div_en),
        .radius (r_reg),
        .sum    (div_sum),
        .quot   (div_q)
    );

    // derived frame sizes, registered from the settled config
    assign total_full = (W_W+H_W)'(w_reg) * (W_W+H_W)'(h_reg);
    assign delay_full = (R_W+W_W)'(r_reg) * (R_W+W_W)'(w_reg) + (R_W+W_W)'(r_reg);

    always_ff @(posedge aclk) begin
        total_reg <= CNT_W'(total_full);
        delay_reg <= DLY_W'(delay_full);
    end

    // ring address arithmetic
    assign step    = (state_reg == sbba_pkg::ST_HADD) ? ADDR_W'(hstep_reg) : ADDR_W'(1);
    assign cur_sum = {1'b0, cursor_reg} + {1'b0, step};
    assign cur_adv = (cur_sum >= (ADDR_W+1)'(LS_DEPTH)) ?
                     ADDR_W'(cur_sum - (ADDR_W+1)'(LS_DEPTH)) : ADDR_W'(cur_sum);
    assign wr_sum  = {1'b0, wr_addr_reg} + (ADDR_W+1)'(1);
    assign wr_adv  = (wr_sum >= (ADDR_W+1)'(LS_DEPTH)) ? '0 : ADDR_W'(wr_sum);
    assign oa_sum  = {1'b0, out_addr_reg} + (ADDR_W+1)'(1);
    assign oa_adv  = (oa_sum >= (ADDR_W+1)'(LS_DEPTH)) ? '0 : ADDR_W'(oa_sum);

    // window placement for the next output pixel
    assign set_hnb = (r_reg != '0) && ((W_W+1)'(ox_reg) >= (W_W+1)'(r_reg)) &&
                     (((W_W+1)'(ox_reg) + (W_W+1)'(r_reg)) < (W_W+1)'(w_reg));
    assign set_vnb = (r_reg != '0) && ((H_W+1)'(oy_reg) >= (H_W+1)'(r_reg)) &&
                     (((H_W+1)'(oy_reg) + (H_W+1)'(r_reg)) < (H_W+1)'(h_reg));
    assign hr = set_hnb ? r_reg : '0;
    assign vr = set_vnb ? r_reg : '0;

    always_comb begin
        if (set_hnb && set_vnb) begin
            offset = ADDR_W'(delay_reg);
        end else if (set_vnb) begin
            offset = ADDR_W'(delay_reg - DLY_W'(r_reg));
        end else if (set_hnb) begin
            offset = ADDR_W'(r_reg);
        end else begin
            offset = '0;
        end
    end

    assign start_sum  = {1'b0, out_addr_reg} + (ADDR_W+1)'(LS_DEPTH) - {1'b0, offset};
    assign start_addr = (start_sum >= (ADDR_W+1)'(LS_DEPTH)) ?
                        ADDR_W'(start_sum - (ADDR_W+1)'(LS_DEPTH)) : ADDR_W'(start_sum);

    // divider feeds the row sum, then the column sum
    assign div_en  = (state_reg == sbba_pkg::ST_HDONE) || (state_reg == sbba_pkg::ST_VDONE);
    assign div_sum = (state_reg == sbba_pkg::ST_VDONE) ? vsum_reg : hsum_reg;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign ls_we     = (state_reg == sbba_pkg::ST_PROC) && !cmd_reg &&
                       (in_count_reg < total_reg);

    assign cfg_hit = cfg_we && ((cfg_addr == sbba_pkg::CFG_BLUR_RADIUS) ||
                                (cfg_addr == sbba_pkg::CFG_IMAGE_WIDTH) ||
                                (cfg_addr == sbba_pkg::CFG_IMAGE_HEIGHT));
    assign cfg_r = cfg_wdata[sbba_pkg::RADIUS_FIELD_W-1:0];
    assign cfg_w = cfg_wdata[sbba_pkg::WIDTH_FIELD_W-1:0];
    assign cfg_h = cfg_wdata[sbba_pkg::HEIGHT_FIELD_W-1:0];

    // sequencer next state and datapath
    always_comb begin
        logic [NCH-1:0][CW-1:0] hval;
        logic [31:0]            opix;

        state_next     = state_reg;
        r_next         = r_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        in_count_next  = in_count_reg;
        wr_addr_next   = wr_addr_reg;
        out_index_next = out_index_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        out_addr_next  = out_addr_reg;
        cursor_next    = cursor_reg;
        hidx_next      = hidx_reg;
        vidx_next      = vidx_reg;
        hlast_next     = hlast_reg;
        vlast_next     = vlast_reg;
        hstep_next     = hstep_reg;
        hnb_next       = hnb_reg;
        vnb_next       = vnb_reg;
        hsum_next      = hsum_reg;
        vsum_next      = vsum_reg;
        cmd_next       = cmd_reg;
        pix_next       = pix_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        s_tready       = 1'b0;

        for (int i = 0; i < NCH; i++) begin
            hval[i] = hnb_reg ? div_q[i] : hsum_reg[i][CW-1:0];
            opix[i*CW +: CW] = vnb_reg ? div_q[i] : vsum_reg[i][CW-1:0];
        end

        // result leaves the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sbba_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd_next   = s_tuser[0];
                    pix_next   = s_tdata;
                    state_next = sbba_pkg::ST_PROC;
                end
            end

            // store the pixel and decide whether an output is due
            sbba_pkg::ST_PROC: begin
                state_next = sbba_pkg::ST_IDLE;
                if (!cmd_reg) begin
                    if (in_count_reg < total_reg) begin
                        in_count_next = in_count_reg + CNT_W'(1);
                        wr_addr_next  = wr_adv;
                        if (((CNT_W+1)'(out_index_reg) + (CNT_W+1)'(delay_reg)) <=
                            (CNT_W+1)'(in_count_reg)) begin
                            state_next = sbba_pkg::ST_SETUP;
                        end
                    end
                end else if ((in_count_reg >= total_reg) && (out_index_reg < in_count_reg)) begin
                    state_next = sbba_pkg::ST_SETUP;
                end
            end

            sbba_pkg::ST_SETUP: begin
                hnb_next    = set_hnb;
                vnb_next    = set_vnb;
                hlast_next  = IDX_W'(hr) << 1;
                vlast_next  = IDX_W'(vr) << 1;
                hstep_next  = w_reg - (W_W'(hr) << 1);
                cursor_next = start_addr;
                hidx_next   = '0;
                vidx_next   = '0;
                hsum_next   = '0;
                vsum_next   = '0;
                state_next  = sbba_pkg::ST_RD;
            end

            sbba_pkg::ST_RD: begin
                state_next = sbba_pkg::ST_ACC;
            end

            // add one tap of the row
            sbba_pkg::ST_ACC: begin
                for (int i = 0; i < NCH; i++) begin
                    hsum_next[i] = hsum_reg[i] + SUM_W'(ls_rd_data[i*CW +: CW]);
                end
                if (hidx_reg == hlast_reg) begin
                    state_next = sbba_pkg::ST_HDONE;
                end else begin
                    hidx_next   = hidx_reg + IDX_W'(1);
                    cursor_next = cur_adv;
                    state_next  = sbba_pkg::ST_RD;
                end
            end

            sbba_pkg::ST_HDONE: begin
                state_next = sbba_pkg::ST_HADD;
            end

            // fold the row result into the column sum
            sbba_pkg::ST_HADD: begin
                for (int i = 0; i < NCH; i++) begin
                    vsum_next[i] = vsum_reg[i] + SUM_W'(hval[i]);
                end
                if (vidx_reg == vlast_reg) begin
                    state_next = sbba_pkg::ST_VDONE;
                end else begin
                    vidx_next   = vidx_reg + IDX_W'(1);
                    hidx_next   = '0;
                    hsum_next   = '0;
                    cursor_next = cur_adv;
                    state_next  = sbba_pkg::ST_RD;
                end
            end

            sbba_pkg::ST_VDONE: begin
                state_next = sbba_pkg::ST_EMIT;
            end

            // load the output register and step the output position
            sbba_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = opix;
                    state_next    = sbba_pkg::ST_IDLE;
                    if (((CNT_W+1)'(out_index_reg) + (CNT_W+1)'(1)) >=
                        (CNT_W+1)'(total_reg)) begin
                        m_tlast_next   = 1'b1;
                        in_count_next  = '0;
                        wr_addr_next   = '0;
                        out_index_next = '0;
                        ox_next        = '0;
                        oy_next        = '0;
                        out_addr_next  = '0;
                    end else begin
                        m_tlast_next   = 1'b0;
                        out_index_next = out_index_reg + CNT_W'(1);
                        out_addr_next  = oa_adv;
                        if ((W_W+1)'(ox_reg) + (W_W+1)'(1) >= (W_W+1)'(w_reg)) begin
                            ox_next = '0;
                            oy_next = oy_reg + H_W'(1);
                        end else begin
                            ox_next = ox_reg + W_W'(1);
                        end
                    end
                end
            end

            default: begin
                state_next = sbba_pkg::ST_IDLE;
            end
        endcase

        // config write: settle the value and restart the frame
        if (cfg_hit) begin
            case (cfg_addr)
                sbba_pkg::CFG_BLUR_RADIUS: begin
                    r_next = (32'(cfg_r) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(cfg_r);
                end
                sbba_pkg::CFG_IMAGE_WIDTH: begin
                    if (cfg_w == '0) begin
                        w_next = W_W'(1);
                    end else if (32'(cfg_w) > MAX_WIDTH) begin
                        w_next = W_W'(MAX_WIDTH);
                    end else begin
                        w_next = W_W'(cfg_w);
                    end
                end
                sbba_pkg::CFG_IMAGE_HEIGHT: begin
                    if (cfg_h == '0) begin
                        h_next = H_W'(1);
                    end else if (32'(cfg_h) > MAX_HEIGHT) begin
                        h_next = H_W'(MAX_HEIGHT);
                    end else begin
                        h_next = H_W'(cfg_h);
                    end
                end
                default: begin
                    r_next = r_reg;
                end
            endcase
            in_count_next  = '0;
            wr_addr_next   = '0;
            out_index_next = '0;
            ox_next        = '0;
            oy_next        = '0;
            out_addr_next  = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbba_pkg::ST_IDLE;
            r_reg         <= '0;
            w_reg         <= W_W'(W_RST);
            h_reg         <= H_W'(H_RST);
            in_count_reg  <= '0;
            wr_addr_reg   <= '0;
            out_index_reg <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            out_addr_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            in_count_reg  <= in_count_next;
            wr_addr_reg   <= wr_addr_next;
            out_index_reg <= out_index_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            out_addr_reg  <= out_addr_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cursor_reg  <= cursor_next;
        hidx_reg    <= hidx_next;
        vidx_reg    <= vidx_next;
        hlast_reg   <= hlast_next;
        vlast_reg   <= vlast_next;
        hstep_reg   <= hstep_next;
        hnb_reg     <= hnb_next;
        vnb_reg     <= vnb_next;
        hsum_reg    <= hsum_next;
        vsum_reg    <= vsum_next;
        cmd_reg     <= cmd_next;
        pix_reg     <= pix_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ hdl/sbba_checker.sv @@
// sbba_checker: port level checks of the box blur unit, bound to the top
// level. Depends on separable_box_blur_argb_unit.
`timescale 1ns / 1ps

module sbba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // one request at a time: busy in the cycle after a request
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

endmodule

bind separable_box_blur_argb_unit sbba_checker u_sbba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ verif/tb.sv @@
// tb: self-checking bench for separable_box_blur_argb_unit, runs directed and random
// frames against an in-bench blur predictor. Depends on sbba_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb;

    localparam int          LS_DEPTH   = 21 * 2048 + 21;
    localparam int          CYCLE_MAX  = 4000000;
    localparam int          SETTLE_CYC = 50;
    localparam bit          CMD_PIXEL  = 1'b0;
    localparam bit          CMD_DRAIN  = 1'b1;

    typedef struct packed {
        bit        cmd;
        bit [31:0] px;
    } request_t;

    typedef struct packed {
        bit [31:0] px;
        bit        last;
    } blurred_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [sbba_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [sbba_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [31:0]                     s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;
    logic                            m_tlast;

    separable_box_blur_argb_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    request_t    req_q[$];
    blurred_t    blur_q[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          took = 1'b0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;

    // predictor state
    bit [31:0]   pix_mem [int unsigned];
    bit [3:0]    radius_reg;
    bit [11:0]   width_reg;
    bit [12:0]   height_reg;
    int unsigned eff_r, eff_w, eff_h;
    int unsigned col_pos, row_pos, next_out;

    function automatic void clamp_geometry();
        eff_r = (radius_reg > 10) ? 10 : radius_reg;
        eff_w = (width_reg == 0) ? 1 : ((width_reg > 2048) ? 2048 : width_reg);
        eff_h = (height_reg == 0) ? 1 : ((height_reg > 4096) ? 4096 : height_reg);
    endfunction

    function automatic int unsigned raw_channel(int unsigned c, int unsigned row, int sh);
        int unsigned idx;
        idx = (row * eff_w + c) % LS_DEPTH;
        return (pix_mem.exists(idx) ? (pix_mem[idx] >> sh) : 0) & 8'hFF;
    endfunction

    function automatic int unsigned row_average(int unsigned c, int unsigned row, int sh);
        int unsigned acc;
        acc = 0;
        if (eff_r == 0 || c < eff_r || c + eff_r >= eff_w)
            return raw_channel(c, row, sh);
        for (int k = 0; k <= 2 * eff_r; k++)
            acc += raw_channel(c - eff_r + k, row, sh);
        return acc / (2 * eff_r + 1);
    endfunction

    function automatic int unsigned column_average(int unsigned c, int unsigned row, int sh);
        int unsigned acc;
        acc = 0;
        if (eff_r == 0 || row < eff_r || row + eff_r >= eff_h)
            return row_average(c, row, sh);
        for (int k = 0; k <= 2 * eff_r; k++)
            acc += row_average(c, row - eff_r + k, sh);
        return acc / (2 * eff_r + 1);
    endfunction

    function automatic void push_blurred(int unsigned total);
        blurred_t b;
        b.px = '0;
        for (int sh = 0; sh < 32; sh += 8)
            b.px |= 32'(column_average(next_out % eff_w, next_out / eff_w, sh)) << sh;
        next_out++;
        b.last = (next_out >= total);
        if (b.last) begin
            col_pos = 0;
            row_pos = 0;
            next_out = 0;
        end
        blur_q.push_back(b);
    endfunction

    function automatic void predict_request(request_t r);
        int unsigned total, cnt, delay;
        total = eff_w * eff_h;
        cnt = row_pos * eff_w + col_pos;
        delay = eff_r * eff_w + eff_r;
        if (r.cmd == CMD_PIXEL) begin
            if (cnt >= total)
                return;
            pix_mem[cnt % LS_DEPTH] = r.px;
            col_pos++;
            if (col_pos >= eff_w) begin
                col_pos = 0;
                row_pos++;
            end
            cnt++;
            if (next_out + delay < cnt)
                push_blurred(total);
        end else if (cnt >= total && next_out < cnt) begin
            push_blurred(total);
        end
    endfunction

    function automatic void predict_config(logic [sbba_pkg::CFG_ADDR_W-1:0] a,
                                           logic [sbba_pkg::CFG_DATA_W-1:0] v);
        case (a)
            sbba_pkg::CFG_BLUR_RADIUS:  radius_reg = v[3:0];
            sbba_pkg::CFG_IMAGE_WIDTH:  width_reg = v[11:0];
            sbba_pkg::CFG_IMAGE_HEIGHT: height_reg = v[12:0];
            default: return;
        endcase
        clamp_geometry();
        col_pos = 0;
        row_pos = 0;
        next_out = 0;
    endfunction

    // monitor: check results, then predict from accepted requests and config writes
    always @(posedge aclk) begin
        blurred_t want;
        took <= s_tvalid && s_tready;
        if (!aresetn) begin
            radius_reg = 0;
            width_reg = sbba_pkg::WIDTH_RST;
            height_reg = sbba_pkg::HEIGHT_RST;
            clamp_geometry();
            col_pos = 0;
            row_pos = 0;
            next_out = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (blur_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result px=%h last=%b", m_tdata, m_tlast);
                end else begin
                    want = blur_q.pop_front();
                    if (want.px !== m_tdata || want.last !== m_tlast) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected px=%h last=%b, got px=%h last=%b",
                                     want.px, want.last, m_tdata, m_tlast);
                    end
                end
            end
            if (cfg_we)
                predict_config(cfg_addr, cfg_wdata);
            if (s_tvalid && s_tready)
                predict_request('{cmd: s_tuser[0], px: s_tdata});
        end
    end

    // driver: next request after an accept or while idle
    always @(negedge aclk) begin
        request_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || took) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 18);
                s_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= r.px;
                s_tuser <= r.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = 400;
            m_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit [31:0] rand_pixel();
        bit [31:0] p;
        p = $urandom;
        for (int ch = 0; ch < 4; ch++)
            if ($urandom_range(0, 7) == 0)
                p[ch*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    task automatic wait_drained();
        do @(posedge aclk);
        while (req_q.size() != 0 || s_tvalid || blur_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(logic [sbba_pkg::CFG_ADDR_W-1:0] a, int unsigned v);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = a;
        cfg_wdata = sbba_pkg::CFG_DATA_W'(v);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(int unsigned r, int unsigned w, int unsigned h);
        wait_drained();
        write_reg(sbba_pkg::CFG_BLUR_RADIUS, r);
        write_reg(sbba_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(sbba_pkg::CFG_IMAGE_HEIGHT, h);
    endtask

    // one well-formed frame with optional noise requests mixed in
    task automatic queue_frame(int unsigned r, int unsigned w, int unsigned h, bit noisy);
        int unsigned er, ew, eh, total, pend;
        er = (r > 10) ? 10 : r;
        ew = (w == 0) ? 1 : ((w > 2048) ? 2048 : w);
        eh = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
        total = ew * eh;
        pend = (er * ew + er < total) ? er * ew + er : total;
        for (int i = 0; i < total; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                req_q.push_back('{cmd: CMD_DRAIN, px: $urandom});
            req_q.push_back('{cmd: CMD_PIXEL, px: rand_pixel()});
        end
        if (noisy && pend > 0)
            repeat ($urandom_range(1, 2)) req_q.push_back('{cmd: CMD_PIXEL, px: $urandom});
        repeat (pend) req_q.push_back('{cmd: CMD_DRAIN, px: $urandom});
        if (noisy && $urandom_range(0, 3) == 0)
            req_q.push_back('{cmd: CMD_DRAIN, px: $urandom});
    endtask

    initial begin
        int unsigned r, w, h, sent;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset geometry passes through; an early drain gives nothing
        req_q.push_back('{cmd: CMD_PIXEL, px: 32'h0000_0000});
        req_q.push_back('{cmd: CMD_PIXEL, px: 32'hFFFF_FFFF});
        req_q.push_back('{cmd: CMD_DRAIN, px: 32'h5A5A_5A5A});
        req_q.push_back('{cmd: CMD_PIXEL, px: 32'hA5C3_3C5A});

        // oversized width and height saturate
        set_geometry(0, 4095, 8191);
        repeat (4) req_q.push_back('{cmd: CMD_PIXEL, px: rand_pixel()});

        // radius above max, zero sizes act as a 1x1 frame
        set_geometry(15, 0, 0);
        queue_frame(15, 0, 0, 1'b0);
        req_q.push_back('{cmd: CMD_DRAIN, px: 32'h0});

        // small frame with ignored pixel after frame input
        set_geometry(1, 3, 3);
        queue_frame(1, 3, 3, 1'b1);

        // widest radius with interior columns, every row border
        set_geometry(10, 22, 3);
        queue_frame(10, 22, 3, 1'b0);

        // narrow frame at max radius: every column is border
        set_geometry(10, 3, 22);
        queue_frame(10, 3, 22, 1'b0);

        // input fills up while the result side is held off
        set_geometry(0, 8, 8);
        hold_req = 1'b1;
        queue_frame(0, 8, 8, 1'b0);

        // random frames
        sent = 0;
        while (sent < 60) begin
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            set_geometry(r, w, h);
            queue_frame(r, w, h, 1'b1);
            sent += w * h;
        end

        // last part runs without idling
        set_geometry(2, 9, 7);
        no_idle = 1'b1;
        queue_frame(2, 9, 7, 1'b1);

        wait_drained();
        repeat (1000) @(posedge aclk);
        if (mismatches == 0 && blur_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
